// ===== rtl/efr_pkg.sv =====
`timescale 1ns / 1ps
package efr_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [7:0]  START_RST   = 8'd126;
    localparam logic [7:0]  ESCAPE_RST  = 8'd125;
    localparam logic [7:0]  END_RST     = 8'd127;
    localparam logic [7:0]  CTRL_RST    = 8'd97;
    localparam logic [7:0]  DATA_RST    = 8'd98;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [8:0]  LEN_ZERO    = 9'd256;
    localparam logic [8:0]  CRC_BYTES   = 9'd4;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_TID     = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_NACK = 2'd2
    } t_kind;

    typedef enum logic [0:0] {
        NACK_CRC  = 1'b0,
        NACK_TYPE = 1'b1
    } t_nack;

    typedef enum logic [2:0] {
        REG_START  = 3'd0,
        REG_ESCAPE = 3'd1,
        REG_END    = 3'd2,
        REG_CTRL   = 3'd3,
        REG_DATA   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] escape_code;
        logic [7:0] end_code;
        logic [7:0] control_type_code;
        logic [7:0] data_type_code;
    } t_codes;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data_byte;
        t_nack      nack_reason;
        logic [7:0] tag;
    } t_result;

    // reflected CRC-32, one byte, eight shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/efr_frame_fsm.sv =====
`timescale 1ns / 1ps
module efr_frame_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  efr_pkg::t_codes     i_codes,
    output efr_pkg::t_result    o_res
);

    efr_pkg::t_phase r_phase, n_phase;
    logic            r_esc, n_esc;
    logic [7:0]      r_tag, n_tag;
    logic [8:0]      r_left, n_left;
    logic [31:0]     r_crc, n_crc;
    logic [31:0]     r_check, n_check;

    logic            is_data;
    efr_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= efr_pkg::PH_IDLE;
            r_esc   <= 1'b0;
            r_tag   <= 8'd0;
            r_left  <= 9'd0;
            r_crc   <= efr_pkg::CRC_INIT;
            r_check <= 32'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_tag   <= n_tag;
            r_left  <= n_left;
            r_crc   <= n_crc;
            r_check <= n_check;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        n_tag   = r_tag;
        n_left  = r_left;
        n_crc   = r_crc;
        n_check = r_check;
        is_data = 1'b0;
        res.valid       = 1'b0;
        res.kind        = efr_pkg::KIND_DATA;
        res.data_byte   = 8'd0;
        res.nack_reason = efr_pkg::NACK_CRC;
        res.tag         = r_tag;

        // an escaped byte is data whatever its value; otherwise start wins over
        // escape, escape over end
        if (r_esc) begin
            n_esc   = 1'b0;
            is_data = 1'b1;
        end else if (i_byte == i_codes.start_code) begin
            n_crc   = efr_pkg::CRC_INIT;
            n_check = 32'd0;
            n_phase = efr_pkg::PH_TID;
        end else if (i_byte == i_codes.escape_code) begin
            n_esc = 1'b1;
        end else if (i_byte == i_codes.end_code) begin
            n_phase = efr_pkg::PH_IDLE;
        end else begin
            is_data = 1'b1;
        end

        if (is_data) begin
            case (r_phase)
                efr_pkg::PH_IDLE: begin
                    n_phase = efr_pkg::PH_IDLE;
                end
                efr_pkg::PH_TID: begin
                    n_tag   = i_byte;
                    n_phase = efr_pkg::PH_TYPE;
                end
                efr_pkg::PH_TYPE: begin
                    if (i_byte == i_codes.control_type_code) begin
                        n_phase = efr_pkg::PH_IDLE;
                    end else if (i_byte == i_codes.data_type_code) begin
                        n_phase = efr_pkg::PH_LEN;
                    end else begin
                        n_phase         = efr_pkg::PH_IDLE;
                        res.valid       = 1'b1;
                        res.kind        = efr_pkg::KIND_NACK;
                        res.nack_reason = efr_pkg::NACK_TYPE;
                    end
                end
                efr_pkg::PH_LEN: begin
                    n_left  = (i_byte == 8'd0) ? efr_pkg::LEN_ZERO : {1'b0, i_byte};
                    n_phase = efr_pkg::PH_PAYLOAD;
                end
                efr_pkg::PH_PAYLOAD: begin
                    n_crc  = efr_pkg::crc_byte(r_crc, i_byte);
                    n_left = r_left - 9'd1;
                    if (n_left == 9'd0) begin
                        n_phase = efr_pkg::PH_CRC;
                        n_left  = efr_pkg::CRC_BYTES;
                    end
                    res.valid     = 1'b1;
                    res.kind      = efr_pkg::KIND_DATA;
                    res.data_byte = i_byte;
                end
                efr_pkg::PH_CRC: begin
                    n_check = {r_check[23:0], i_byte};
                    n_left  = r_left - 9'd1;
                    if (n_left == 9'd0) begin
                        n_phase   = efr_pkg::PH_IDLE;
                        res.valid = 1'b1;
                        res.kind  = ((~r_crc) == n_check) ? efr_pkg::KIND_ACK
                                                          : efr_pkg::KIND_NACK;
                    end
                end
                default: begin
                    n_phase = efr_pkg::PH_IDLE;
                end
            endcase
        end

        o_res       = res;
        o_res.valid = res.valid & i_step;
    end

endmodule

// ===== rtl/escaped_frame_receiver_crc32_top.sv =====
`timescale 1ns / 1ps
// Byte-stuffed frame receiver with CRC-32 check.
// Input channel: i_rx_valid / o_rx_ready carry one raw link byte per request
// on i_rx_byte. Output channel: o_res_valid / i_res_ready carry one result per
// request: a tentative payload byte (o_kind data), or an ack / nack with the
// frame's transaction id on o_transaction_tag and the nack cause.
// A byte goes into an input register, then one pass of the frame state machine
// and byte-wide CRC update writes the result register when the output is not
// stalled. One byte is taken every cycle while the output is not stalled; the
// CRC update and the phase step in a single pass set that rate. Bytes that give
// no result (controls, header bytes but a bad type, CRC bytes but the last)
// leave the output idle.
// Control codes and type codes are written over the APB port; the user must write
// them only while the block is idle; the block does not enforce it. Synchronous
// active-low reset returns the codes to their defaults, the frame state to idle
// and drops any pending request. When the receiver stalls, the result register
// holds and the input register fills; o_rx_ready drops until the result is taken.
module escaped_frame_receiver_crc32_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [efr_pkg::ADDR_W-1:0]  paddr,
    input  logic [efr_pkg::DATA_W-1:0]  pwdata,
    output logic [efr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_rx_valid,
    output logic                        o_rx_ready,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_data_byte,
    output logic                        o_nack_reason,
    output logic [7:0]                  o_transaction_tag
);

    efr_pkg::t_codes  r_codes;
    efr_pkg::t_result res;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    efr_pkg::t_kind   r_kind;
    logic [7:0]       r_data;
    efr_pkg::t_nack   r_reason;
    logic [7:0]       r_tag;
    logic             advance;
    logic             cfg_wr;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.start_code        <= efr_pkg::START_RST;
            r_codes.escape_code       <= efr_pkg::ESCAPE_RST;
            r_codes.end_code          <= efr_pkg::END_RST;
            r_codes.control_type_code <= efr_pkg::CTRL_RST;
            r_codes.data_type_code    <= efr_pkg::DATA_RST;
        end else if (cfg_wr) begin
            unique case (efr_pkg::t_reg_idx'(paddr[4:2]))
                efr_pkg::REG_START:  r_codes.start_code        <= pwdata[7:0];
                efr_pkg::REG_ESCAPE: r_codes.escape_code       <= pwdata[7:0];
                efr_pkg::REG_END:    r_codes.end_code          <= pwdata[7:0];
                efr_pkg::REG_CTRL:   r_codes.control_type_code <= pwdata[7:0];
                efr_pkg::REG_DATA:   r_codes.data_type_code    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (efr_pkg::t_reg_idx'(paddr[4:2]))
            efr_pkg::REG_START:  prdata = {24'd0, r_codes.start_code};
            efr_pkg::REG_ESCAPE: prdata = {24'd0, r_codes.escape_code};
            efr_pkg::REG_END:    prdata = {24'd0, r_codes.end_code};
            efr_pkg::REG_CTRL:   prdata = {24'd0, r_codes.control_type_code};
            efr_pkg::REG_DATA:   prdata = {24'd0, r_codes.data_type_code};
            default:             prdata = '0;
        endcase
    end

    // two-stage flow: input register, then result register
    assign advance    = ~r_out_valid | i_res_ready;
    assign o_rx_ready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    efr_frame_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_valid & advance),
        .i_byte  (r_in_byte),
        .i_codes (r_codes),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_kind   <= res.kind;
            r_data   <= res.data_byte;
            r_reason <= res.nack_reason;
            r_tag    <= res.tag;
        end
    end

    assign o_res_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_data_byte       = r_data;
    assign o_nack_reason     = r_reason;
    assign o_transaction_tag = r_tag;

endmodule

// ===== test/efr_result_checker.sv =====
`timescale 1ns / 1ps
package efr_tb_pkg;

    import efr_pkg::*;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        t_nack      reason;
        logic [7:0] tag;
    } t_response;

    // bit-serial form of the reflected CRC-32 update, LSB of the byte first
    function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

endpackage

module efr_result_checker
    import efr_pkg::*;
    import efr_tb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    input  logic              i_pready,
    input  logic              i_rx_valid,
    input  logic              i_rx_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_data_byte,
    input  logic              i_nack_reason,
    input  logic [7:0]        i_tag,
    output int                o_mismatches,
    output int                o_awaited,
    output int                o_checked
);

    t_codes      codes;
    t_phase      phase;
    logic        esc_armed;
    logic [7:0]  frame_tag;
    logic [8:0]  left;
    logic [31:0] crc;
    logic [31:0] check_word;
    t_response   awaited[$];
    int          mismatches = 0;
    int          checked = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic owe(input t_kind kind, input logic [7:0] data, input t_nack reason);
        t_response r;
        r.kind   = kind;
        r.data   = data;
        r.reason = reason;
        r.tag    = frame_tag;
        awaited.insert(awaited.size(), r);
    endtask

    task automatic frame_step(input logic [7:0] b);
        case (phase)
            PH_TID: begin
                frame_tag = b;
                phase = PH_TYPE;
            end
            PH_TYPE: begin
                // control wins when both type codes match
                if (b == codes.control_type_code) begin
                    phase = PH_IDLE;
                end else if (b == codes.data_type_code) begin
                    phase = PH_LEN;
                end else begin
                    phase = PH_IDLE;
                    owe(KIND_NACK, 8'd0, NACK_TYPE);
                end
            end
            PH_LEN: begin
                left = (b == 8'd0) ? LEN_ZERO : {1'b0, b};
                phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                crc = crc32_next(crc, b);
                left = left - 9'd1;
                if (left == 9'd0) begin
                    phase = PH_CRC;
                    left = CRC_BYTES;
                end
                owe(KIND_DATA, b, NACK_CRC);
            end
            PH_CRC: begin
                check_word = {check_word[23:0], b};
                left = left - 9'd1;
                if (left == 9'd0) begin
                    phase = PH_IDLE;
                    if (~crc == check_word) begin
                        owe(KIND_ACK, 8'd0, NACK_CRC);
                    end else begin
                        owe(KIND_NACK, 8'd0, NACK_CRC);
                    end
                end
            end
            default: phase = PH_IDLE;
        endcase
    endtask

    task automatic take_link_byte(input logic [7:0] b);
        if (esc_armed) begin
            esc_armed = 1'b0;
            frame_step(b);
        end else if (b == codes.start_code) begin
            crc = CRC_INIT;
            check_word = 32'd0;
            phase = PH_TID;
        end else if (b == codes.escape_code) begin
            esc_armed = 1'b1;
        end else if (b == codes.end_code) begin
            phase = PH_IDLE;
        end else begin
            frame_step(b);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_response want;
        if (!i_rst_n) begin
            codes = '{START_RST, ESCAPE_RST, END_RST, CTRL_RST, DATA_RST};
            phase = PH_IDLE;
            esc_armed = 1'b0;
            frame_tag = 8'd0;
            left = 9'd0;
            crc = CRC_INIT;
            check_word = 32'd0;
            awaited.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (awaited.size() == 0) begin
                    report("result with none awaited, kind", 32'(i_kind), 32'd0);
                end else begin
                    want = awaited.pop_front();
                    checked++;
                    if (i_kind !== want.kind)
                        report("kind", 32'(i_kind), 32'(want.kind));
                    if (i_data_byte !== want.data)
                        report("data_byte", 32'(i_data_byte), 32'(want.data));
                    if (i_nack_reason !== want.reason)
                        report("nack_reason", 32'(i_nack_reason), 32'(want.reason));
                    if (i_tag !== want.tag)
                        report("transaction_tag", 32'(i_tag), 32'(want.tag));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_W-1:2]))
                    REG_START:  codes.start_code = i_pwdata[7:0];
                    REG_ESCAPE: codes.escape_code = i_pwdata[7:0];
                    REG_END:    codes.end_code = i_pwdata[7:0];
                    REG_CTRL:   codes.control_type_code = i_pwdata[7:0];
                    REG_DATA:   codes.data_type_code = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_rx_valid && i_rx_ready) take_link_byte(i_rx_byte);
        end
        o_awaited <= awaited.size();
        o_mismatches <= mismatches;
        o_checked <= checked;
    end

endmodule

// ===== test/tb_escaped_frame_receiver_crc32_top.sv =====
`timescale 1ns / 1ps
module tb_escaped_frame_receiver_crc32_top;

    import efr_pkg::*;
    import efr_tb_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 1000;
    localparam int BUDGET      = 12;

    // last entry is run with both sides streaming
    localparam t_codes PLAN [0:6] = '{
        '{8'd126, 8'd125, 8'd127, 8'd97, 8'd98},
        '{8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF},
        '{8'hFF, 8'h00, 8'h01, 8'h07, 8'h07},
        '{8'h5A, 8'hA5, 8'h5A, 8'h01, 8'h02},
        '{8'h3C, 8'hC3, 8'hC3, 8'h40, 8'h80},
        '{8'h11, 8'h11, 8'h22, 8'hFF, 8'h00},
        '{8'd126, 8'd125, 8'd127, 8'd97, 8'd98}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_rx_valid = 1'b0;
    logic              o_rx_ready;
    logic [7:0]        i_rx_byte = 8'd0;
    logic              o_res_valid;
    logic              i_res_ready = 1'b0;
    logic [1:0]        o_kind;
    logic [7:0]        o_data_byte;
    logic              o_nack_reason;
    logic [7:0]        o_transaction_tag;

    int          mismatches;
    int          awaited;
    int          results;
    int          quiet_cycles = 0;
    int          n_bytes = 0;
    int          n_frames = 0;
    int          gap_odds = 0;
    bit          steady = 1'b0;
    t_codes      cur = '{START_RST, ESCAPE_RST, END_RST, CTRL_RST, DATA_RST};
    logic [7:0]  body[$];

    escaped_frame_receiver_crc32_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_rx_valid        (i_rx_valid),
        .o_rx_ready        (o_rx_ready),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_kind            (o_kind),
        .o_data_byte       (o_data_byte),
        .o_nack_reason     (o_nack_reason),
        .o_transaction_tag (o_transaction_tag)
    );

    efr_result_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .i_rx_valid    (i_rx_valid),
        .i_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .i_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .i_kind        (o_kind),
        .i_data_byte   (o_data_byte),
        .i_nack_reason (o_nack_reason),
        .i_tag         (o_transaction_tag),
        .o_mismatches  (mismatches),
        .o_awaited     (awaited),
        .o_checked     (results)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result side: random stall bursts, always ready once steady
    initial begin
        @(posedge i_clk);
        forever begin
            if (steady) begin
                i_res_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_res_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_res_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // the return to idle after each access keeps back-to-back writes apart
    task automatic write_reg(input t_reg_idx idx, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off until every result is back and the pipe has emptied
    task automatic drain();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (!steady && gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        n_bytes++;
    endtask

    task automatic send_plain(input logic [7:0] b);
        if (b == cur.start_code || b == cur.escape_code || b == cur.end_code)
            send_byte(cur.escape_code);
        send_byte(b);
    endtask

    // cut >= 0 aborts with the end code after that many payload/CRC bytes
    task automatic send_frame(input logic [7:0] tid, input logic [7:0] mtype,
                              input bit bad_crc, input int cut);
        logic [31:0] acc;
        int          pos;
        acc = CRC_INIT;
        pos = 0;
        send_byte(cur.start_code);
        send_plain(tid);
        send_plain(mtype);
        if (mtype == cur.control_type_code || mtype != cur.data_type_code) begin
            // trailing bytes should be dropped while idle
            repeat ($urandom_range(0, 3)) send_plain(8'($urandom));
            return;
        end
        send_plain(body.size() == 256 ? 8'd0 : 8'(body.size()));
        foreach (body[k]) begin
            if (pos == cut) begin
                send_byte(cur.end_code);
                return;
            end
            send_plain(body[k]);
            acc = crc32_next(acc, body[k]);
            pos++;
        end
        acc = ~acc;
        if (bad_crc) acc = acc ^ (32'd1 << $urandom_range(0, 31));
        for (int k = 3; k >= 0; k--) begin
            if (pos == cut) begin
                send_byte(cur.end_code);
                return;
            end
            send_plain(acc[8*k +: 8]);
            pos++;
        end
        n_frames++;
    endtask

    task automatic random_traffic(input int budget);
        int stop;
        int r;
        int n;
        stop = n_bytes + budget;
        while (n_bytes < stop) begin
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 25;
            r = $urandom_range(0, 99);
            n = $urandom_range(1, 10);
            body.delete();
            repeat (n) body.insert(body.size(), 8'($urandom));
            if (r < 60) begin
                send_frame(8'($urandom), cur.data_type_code, $urandom_range(0, 6) == 0, -1);
            end else if (r < 70) begin
                send_frame(8'($urandom), 8'($urandom), 1'b0, -1);
            end else if (r < 75) begin
                send_frame(8'($urandom), cur.control_type_code, 1'b0, -1);
            end else if (r < 87) begin
                send_frame(8'($urandom), cur.data_type_code, 1'b0, $urandom_range(0, n + 3));
            end else if (r < 93) begin
                // half a header, left open for whatever comes next
                send_byte(cur.start_code);
                send_plain(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: escaped controls in payload, tag extremes, both nacks, control, abort
        body = '{8'h7E, 8'h7F, 8'h7D};
        send_frame(8'hFF, cur.data_type_code, 1'b0, -1);
        body = '{8'h00};
        send_frame(8'h00, cur.data_type_code, 1'b1, -1);
        send_frame(8'h5C, 8'h00, 1'b0, -1);
        send_frame(8'h11, cur.control_type_code, 1'b0, -1);
        body = '{8'hAA, 8'hFF};
        send_frame(8'h33, cur.data_type_code, 1'b0, 0);

        // length byte of zero: 256 payload bytes
        gap_odds = 10;
        body.delete();
        repeat (256) body.insert(body.size(), 8'($urandom));
        send_frame(8'($urandom), cur.data_type_code, 1'b0, -1);

        foreach (PLAN[s]) begin
            drain();
            if (s == $size(PLAN) - 1) steady = 1'b1;
            write_reg(REG_START, PLAN[s].start_code);
            write_reg(REG_ESCAPE, PLAN[s].escape_code);
            write_reg(REG_END, PLAN[s].end_code);
            write_reg(REG_CTRL, PLAN[s].control_type_code);
            write_reg(REG_DATA, PLAN[s].data_type_code);
            cur = PLAN[s];
            random_traffic(BUDGET);
        end

        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d link bytes, %0d whole frames, %0d results checked",
                 n_bytes, n_frames, results);
        $display("%0d code settings incl. equal type codes and overlapping control codes",
                 $size(PLAN));
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
